/* rtl/prs_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// prs_pkg
// Shared types, constants and helpers for the population replication step.
// ---------------------------------------------------------------------------
package prs_pkg;

  // field widths
  localparam int IDX_W      = 7;
  localparam int STR_W      = 16;
  localparam int RATE_W     = 17;
  localparam int RAD_W      = 5;
  localparam int DIST_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int HALF_W     = STR_W / 2;
  localparam int HCNT_W     = $clog2(HALF_W + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MASTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_NEAR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_FLAT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_RADIUS = 3'd3;

  // configuration reset values
  localparam logic [RATE_W-1:0] RST_RATE_MASTER = 17'd65536;
  localparam logic [RATE_W-1:0] RST_RATE_NEAR   = 17'd164;
  localparam logic [RATE_W-1:0] RST_RATE_FLAT   = 17'd16384;
  localparam logic [RAD_W-1:0]  RST_NEAR_RADIUS = 5'd5;

  // item function codes
  localparam logic FUNC_REPL = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_SAME = 2'd1,
    KIND_COPY = 2'd2
  } kind_e;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  source_index;
    logic [IDX_W-1:0]  target_index;
    logic [STR_W-1:0]  replicate_draw;
    logic [STR_W-1:0]  mutation_mask;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    logic [STR_W-1:0]  entry_value;
    logic [DIST_W-1:0] distance;
    logic              replicated;
    logic              status;
  } out_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_master;
    logic [RATE_W-1:0] rate_near;
    logic [RATE_W-1:0] rate_flat;
    logic [RAD_W-1:0]  near_radius;
  } cfg_t;

  // classified job passed from front to back, indices already wrapped
  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  src_idx;
    logic [IDX_W-1:0]  dst_idx;
    logic [STR_W-1:0]  draw;
    logic [STR_W-1:0]  mask;
  } job_t;

  // number of zero bits in a string, counted as two halves
  function automatic logic [DIST_W-1:0] zero_count(input logic [STR_W-1:0] v);
    logic [HCNT_W-1:0] lo;
    logic [HCNT_W-1:0] hi;
    lo = '0;
    hi = '0;
    for (int k = 0; k < HALF_W; k++) begin
      lo = lo + HCNT_W'(!v[k]);
      hi = hi + HCNT_W'(!v[k + HALF_W]);
    end
    return DIST_W'(lo) + DIST_W'(hi);
  endfunction

endpackage
`default_nettype wire

/* rtl/prs_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// prs_ram
// Generic RAM, one write port and two read ports with registered read data.
// ---------------------------------------------------------------------------
module prs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]              rdata_a_o,
  output logic [WIDTH-1:0]              rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads, data holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/prs_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// prs_front
// Accepts items, wraps indices, classifies them and queues them for the back.
// ---------------------------------------------------------------------------
module prs_front #(
  parameter int POP_SIZE = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire prs_pkg::in_item_t in_item_i,
  output logic                   job_valid_o,
  output prs_pkg::job_t          job_o,
  input  wire logic              job_pop_i
);
  import prs_pkg::*;

  localparam int IDX_N   = 1 << IDX_W;
  localparam int DEPTH   = (POP_SIZE < IDX_N) ? POP_SIZE : IDX_N;
  localparam int Q_DEPTH = 2;
  localparam int PTR_W   = $clog2(Q_DEPTH);

  logic [IDX_W-1:0] wrap_tab [IDX_N];
  logic [IDX_W-1:0] src_w;
  logic [IDX_W-1:0] dst_w;
  job_t             job_new;
  logic             push;

  job_t             job_mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  // index wrap table, worked out at elaboration
  for (genvar g = 0; g < IDX_N; g++) begin : g_wrap
    assign wrap_tab[g] = IDX_W'(g % DEPTH);
  end

  // classify the incoming item
  always_comb begin
    src_w = wrap_tab[in_item_i.source_index];
    dst_w = wrap_tab[in_item_i.target_index];
    job_new.src_idx = src_w;
    job_new.dst_idx = dst_w;
    job_new.draw    = in_item_i.replicate_draw;
    job_new.mask    = in_item_i.mutation_mask;
    if (in_item_i.func == FUNC_READ) begin
      job_new.kind = KIND_READ;
    end else if (src_w == dst_w) begin
      job_new.kind = KIND_SAME;
    end else begin
      job_new.kind = KIND_COPY;
    end
  end

  assign in_ready_o  = (cnt_q != (PTR_W+1)'(Q_DEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = job_mem_q[rd_ptr_q];

  // queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (job_pop_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push && !job_pop_i) begin
      cnt_d = cnt_q + (PTR_W+1)'(1);
    end else if (!push && job_pop_i) begin
      cnt_d = cnt_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      job_mem_q[wr_ptr_q] <= job_new;
    end
  end

endmodule
`default_nettype wire

/* rtl/prs_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// prs_back
// Executes queued jobs: reads the store, picks the rate, writes the copy and
// holds the result item in the output register.
// ---------------------------------------------------------------------------
module prs_back #(
  parameter int POP_SIZE = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire prs_pkg::cfg_t      cfg_i,
  input  wire logic               job_valid_i,
  input  wire prs_pkg::job_t      job_i,
  output logic                    job_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output prs_pkg::out_item_t      out_item_o
);
  import prs_pkg::*;

  localparam int IDX_N  = 1 << IDX_W;
  localparam int DEPTH  = (POP_SIZE < IDX_N) ? POP_SIZE : IDX_N;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic ST_READ = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic              state_q, state_d;
  job_t              job_q;
  logic [DEPTH-1:0]  vld_q, vld_d;
  logic              src_vld_q, dst_vld_q;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q;

  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] dst_addr;
  logic [ADDR_W-1:0] dst_addr_q;
  logic [STR_W-1:0]  rdata_a;
  logic [STR_W-1:0]  rdata_b;
  logic [STR_W-1:0]  src_val;
  logic [STR_W-1:0]  dst_val;
  logic [STR_W-1:0]  new_val;
  logic [DIST_W-1:0] src_dist;
  logic [RATE_W-1:0] rate;
  logic              accept;
  logic              load;
  logic              we;
  out_item_t         res;

  assign src_addr   = job_i.src_idx[ADDR_W-1:0];
  assign dst_addr   = job_i.dst_idx[ADDR_W-1:0];
  assign dst_addr_q = job_q.dst_idx[ADDR_W-1:0];
  assign job_pop_o  = (state_q == ST_READ) && job_valid_i;

  // population store
  prs_ram #(
    .WIDTH(STR_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (dst_addr_q),
    .wdata_i  (new_val),
    .re_i     (job_pop_o),
    .raddr_a_i(src_addr),
    .raddr_b_i(dst_addr),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // entries never written read as the master string
  assign src_val  = src_vld_q ? rdata_a : '1;
  assign dst_val  = dst_vld_q ? rdata_b : '1;
  assign new_val  = src_val ^ job_q.mask;
  assign src_dist = zero_count(src_val);

  // rate select and acceptance
  always_comb begin
    if (src_dist == '0) begin
      rate = cfg_i.rate_master;
    end else if (src_dist <= cfg_i.near_radius) begin
      rate = cfg_i.rate_near;
    end else begin
      rate = cfg_i.rate_flat;
    end
    accept = ({1'b0, job_q.draw} <= rate);
  end

  // result item
  always_comb begin
    res.distance    = src_dist;
    res.entry_index = job_q.dst_idx;
    res.entry_value = dst_val;
    res.replicated  = 1'b0;
    res.status      = 1'b0;
    case (job_q.kind)
      KIND_READ: begin
        res.entry_index = job_q.src_idx;
        res.entry_value = src_val;
      end
      KIND_SAME: begin
        res.status = 1'b1;
      end
      KIND_COPY: begin
        if (accept) begin
          res.replicated  = 1'b1;
          res.entry_value = new_val;
        end
      end
      default: begin
        res.entry_value = dst_val;
      end
    endcase
  end

  assign load = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign we   = load && res.replicated;

  // sequencer, valid bits and output handshake
  always_comb begin
    state_d     = state_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_READ: begin
        if (job_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (load) begin
          out_valid_d = 1'b1;
          state_d     = ST_READ;
          if (we) begin
            vld_d[dst_addr_q] = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_READ;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READ;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // job and result payload
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q     <= job_i;
      src_vld_q <= vld_q[src_addr];
      dst_vld_q <= vld_q[dst_addr];
    end
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

/* rtl/population_replication_step_top.sv */
// A result item passes through the input queue, the registered store read
// and the output register, where it waits while the output is stalled.
// The back end takes no new job until the current one has passed the store
// read and the execute and write-back step.
// Reset clears control state and marks every entry as the all-ones master
// string at once; configuration registers return to their reset values.
`default_nettype none
// ---------------------------------------------------------------------------
// population_replication_step_top
// Population store with replication events and entry reads.
// ---------------------------------------------------------------------------
module population_replication_step_top #(
  parameter int POP_SIZE = 128
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire prs_pkg::in_item_t                  in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output prs_pkg::out_item_t                      out_item_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [prs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [prs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import prs_pkg::*;

  cfg_t cfg_q;
  logic job_valid;
  job_t job;
  logic job_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_master <= RST_RATE_MASTER;
      cfg_q.rate_near   <= RST_RATE_NEAR;
      cfg_q.rate_flat   <= RST_RATE_FLAT;
      cfg_q.near_radius <= RST_NEAR_RADIUS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RATE_MASTER: cfg_q.rate_master <= cfg_data_i[RATE_W-1:0];
        CFG_RATE_NEAR:   cfg_q.rate_near   <= cfg_data_i[RATE_W-1:0];
        CFG_RATE_FLAT:   cfg_q.rate_flat   <= cfg_data_i[RATE_W-1:0];
        CFG_NEAR_RADIUS: cfg_q.near_radius <= cfg_data_i[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // accept and classify
  prs_front #(
    .POP_SIZE(POP_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_pop_i  (job_pop)
  );

  // execute against the store
  prs_back #(
    .POP_SIZE(POP_SIZE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(job_valid),
    .job_i      (job),
    .job_pop_o  (job_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire
